// File: src/cust_pkg.sv
// ----------------------------------------------------------------------------
// cust_pkg
// Shared constants, codes and types for the compacting unique set table.
// ----------------------------------------------------------------------------
package cust_pkg;

  localparam int CAPACITY    = 64;
  localparam int HANDLE_BITS = 32;

  // fixed field widths of the ports
  localparam int HANDLE_W = 32;
  localparam int OCC_W    = 7;

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef logic [HANDLE_BITS-1:0] key_t;
  typedef logic [AW-1:0]          addr_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_NONE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    key_t  wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic             present;
    status_t          status;
    logic [OCC_W-1:0] occupancy;
  } res_t;

endpackage

// File: src/cust_mem.sv
// ----------------------------------------------------------------------------
// cust_mem
// Entry store: one write port and one registered read port.
// ----------------------------------------------------------------------------
module cust_mem (
  input  logic               clk,
  input  cust_pkg::mem_req_t req,
  output cust_pkg::key_t     rdata
);
  import cust_pkg::*;

  key_t mem [CAPACITY];
  key_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/cust_seq.sv
// ----------------------------------------------------------------------------
// cust_seq
// Sequencer with the shared compare unit: walks the entries one per cycle
// to find a handle, then moves later entries down one slot on a remove.
// ----------------------------------------------------------------------------
module cust_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_accept,
  input  cust_pkg::action_t  in_act,
  input  cust_pkg::key_t     in_key,
  output logic               busy,
  output cust_pkg::mem_req_t mem_req,
  input  cust_pkg::key_t     rdata,
  output logic               res_valid,
  input  logic               res_ready,
  output cust_pkg::res_t     res
);
  import cust_pkg::*;

  state_t  state_r, state_nxt;
  action_t act_r, act_nxt;
  key_t    key_r, key_nxt;
  cnt_t    cnt_r, cnt_nxt;
  cnt_t    idx_r, idx_nxt;
  logic    pend_r, pend_nxt;
  cnt_t    pidx_r, pidx_nxt;
  logic    present_r, present_nxt;
  status_t status_r, status_nxt;

  logic hit;
  logic more;
  logic walk_end;
  logic add_ok;
  cnt_t pidx_dec;

  // one compare per cycle against the entry read in the previous cycle
  assign hit      = pend_r && (rdata == key_r);
  assign more     = idx_r < cnt_r;
  assign walk_end = hit || (!more && !pend_r);
  assign add_ok   = !hit && (cnt_r != cnt_t'(CAPACITY));
  assign pidx_dec = pidx_r - cnt_t'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (walk_end) begin
          state_nxt = (act_r == ACT_REMOVE && hit) ? S_SHIFT : S_DONE;
        end
      end
      S_SHIFT: begin
        if (!more && !pend_r) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath registers
  always_comb begin
    act_nxt     = act_r;
    key_nxt     = key_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    pend_nxt    = pend_r;
    pidx_nxt    = pidx_r;
    present_nxt = present_r;
    status_nxt  = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          act_nxt  = in_act;
          key_nxt  = in_key;
          idx_nxt  = '0;
          pend_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        if (walk_end) begin
          present_nxt = hit;
          pend_nxt    = 1'b0;
          status_nxt  = STAT_DONE;
          case (act_r)
            ACT_ADD: begin
              if (hit) begin
                status_nxt = STAT_NONE;
              end else if (!add_ok) begin
                status_nxt = STAT_FULL;
              end else begin
                cnt_nxt = cnt_r + cnt_t'(1);
              end
            end
            ACT_REMOVE: begin
              if (!hit) status_nxt = STAT_NONE;
              idx_nxt = pidx_r + cnt_t'(1);
            end
            ACT_CLEAR: cnt_nxt = '0;
            default: ;
          endcase
        end else if (more) begin
          idx_nxt  = idx_r + cnt_t'(1);
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      S_SHIFT: begin
        if (more) begin
          idx_nxt  = idx_r + cnt_t'(1);
          pend_nxt = 1'b1;
          pidx_nxt = idx_r;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) cnt_nxt = cnt_r - cnt_t'(1);
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    mem_req       = '0;
    mem_req.wdata = key_r;
    busy          = 1'b1;
    res_valid     = 1'b0;
    unique case (state_r)
      S_IDLE: busy = 1'b0;
      S_SCAN: begin
        mem_req.re    = more;
        mem_req.raddr = idx_r[AW-1:0];
        mem_req.we    = walk_end && (act_r == ACT_ADD) && add_ok;
        mem_req.waddr = cnt_r[AW-1:0];
      end
      S_SHIFT: begin
        mem_req.re    = more;
        mem_req.raddr = idx_r[AW-1:0];
        mem_req.we    = pend_r;
        mem_req.waddr = pidx_dec[AW-1:0];
        mem_req.wdata = rdata;
      end
      S_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res.present   = present_r;
  assign res.status    = status_r;
  assign res.occupancy = OCC_W'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    key_r     <= key_nxt;
    pidx_r    <= pidx_nxt;
    present_r <= present_nxt;
    status_r  <= status_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(CAPACITY))
    else $error("entry count above capacity");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !in_accept) |=> state_r == S_IDLE)
    else $error("sequencer left idle without a transaction");

  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && mem_req.we) |-> (pidx_dec < cnt_r))
    else $error("shift writes beyond the occupied entries");

  a_cnt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |=> $stable(cnt_r))
    else $error("entry count changed outside a request");

endmodule

// File: src/compacting_unique_set_table.sv
// ----------------------------------------------------------------------------
// compacting_unique_set_table
// Bounded set of handles kept in insertion order with add, remove, query
// and clear requests, each answered by one result transaction.
// ----------------------------------------------------------------------------
// One request is in work at a time. Every request first walks the occupied
// entries through the single read port of the entry store, one entry per
// cycle, stopping at the first match. A remove that hits then moves each
// later entry down one slot, one entry per cycle. The finished result then
// waits in the sequencer until the output register can take it, and the
// next request is taken only after that. The input is stalled while a
// request is in work and while a finished result waits in a full, stalled
// output register. No clearing pass is needed after reset.
module compacting_unique_set_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [cust_pkg::HANDLE_W-1:0] in_handle,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_present,
  output logic [1:0]                    out_status,
  output logic [cust_pkg::OCC_W-1:0]    out_occupancy
);
  import cust_pkg::*;

  logic     busy;
  logic     in_accept;
  logic     res_valid;
  logic     res_ready;
  res_t     res;
  mem_req_t mem_req;
  key_t     rdata;

  logic     out_valid_r, out_valid_nxt;
  res_t     out_r;

  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;
  assign res_ready = !out_valid_r || !out_stall;

  cust_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_act    (action_t'(in_action)),
    .in_key    (HANDLE_BITS'(in_handle)),
    .busy      (busy),
    .mem_req   (mem_req),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  cust_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_present   = out_r.present;
  assign out_status    = out_r.status;
  assign out_occupancy = out_r.occupancy;

endmodule

// File: sim/compacting_unique_set_table_check.sv
// ----------------------------------------------------------------------------
// compacting_unique_set_table_check
// Watches both channels of the set table, keeps its own copy of the member
// list, predicts one result per accepted request and compares every field.
// ----------------------------------------------------------------------------
module compacting_unique_set_table_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [1:0]                    in_action,
  input  logic [cust_pkg::HANDLE_W-1:0] in_handle,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_present,
  input  logic [1:0]                    out_status,
  input  logic [cust_pkg::OCC_W-1:0]    out_occupancy,
  output int                            fail_count,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import cust_pkg::*;

  key_t member_handles [CAPACITY];
  int   member_count;
  res_t pending_results [$];
  int   mismatches = 0;

  // updates the member list and returns what the table should answer
  function automatic res_t apply_request(action_t act, key_t h);
    res_t r;
    int   slot;
    bit   hit;
    slot = member_count;
    hit  = 1'b0;
    for (int i = 0; i < member_count; i++) begin
      if (!hit && member_handles[i] == h) begin
        slot = i;
        hit  = 1'b1;
      end
    end
    r.present = hit;
    r.status  = STAT_DONE;
    case (act)
      ACT_ADD: begin
        if (hit) begin
          r.status = STAT_NONE;
        end else if (member_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          member_handles[member_count] = h;
          member_count++;
        end
      end
      ACT_REMOVE: begin
        if (!hit) begin
          r.status = STAT_NONE;
        end else begin
          // later entries move down one slot
          for (int i = slot; i + 1 < member_count; i++) begin
            member_handles[i] = member_handles[i + 1];
          end
          member_count--;
        end
      end
      ACT_CLEAR: begin
        member_count = 0;
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(member_count);
    return r;
  endfunction

  function automatic int field_mismatch(string field, logic [31:0] want, logic [31:0] got);
    if (got === want) begin
      return 0;
    end
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      member_count = 0;
      pending_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(apply_request(action_t'(in_action), key_t'(in_handle)));
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, got present %0h "
                   , $time, out_present, "status %0h occupancy %0d", out_status, out_occupancy);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          mismatches += field_mismatch("present", 32'(want.present), 32'(out_present));
          mismatches += field_mismatch("status", 32'(want.status), 32'(out_status));
          mismatches += field_mismatch("occupancy", 32'(want.occupancy),
                                       32'(out_occupancy));
        end
      end
    end
    fail_count  <= mismatches;
    outstanding <= pending_results.size();
  end

endmodule

// File: sim/compacting_unique_set_table_test.sv
// ----------------------------------------------------------------------------
// compacting_unique_set_table_test
// Drives directed and random add, remove, query and clear requests into the
// set table under several idle and stall patterns, including a long output
// hold-off, and reports the verdict from the attached checker.
// ----------------------------------------------------------------------------
module compacting_unique_set_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cust_pkg::*;

  localparam int      PHASE_ITEMS  = 500;
  localparam int      HOLD_CYCLES  = 400;
  localparam int      POOL_SIZE    = CAPACITY + 16;
  localparam int      DRAIN_CYCLES = 2 * CAPACITY + 16;
  localparam longint  LIMIT_NS     = 60_000_000;

  localparam logic [HANDLE_W-1:0] H_ZERO = '0;
  localparam logic [HANDLE_W-1:0] H_ONES = '1;
  localparam logic [HANDLE_W-1:0] H_ALT0 = 32'hAAAA_5555;
  localparam logic [HANDLE_W-1:0] H_ALT1 = 32'h5555_AAAA;
  localparam logic [HANDLE_W-1:0] H_MSB  = 32'h8000_0000;
  localparam logic [HANDLE_W-1:0] H_LSB  = 32'h0000_0001;

  localparam int MODE_FILL  = 0;
  localparam int MODE_CHURN = 1;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_action;
  logic [HANDLE_W-1:0] in_handle;
  logic                out_valid;
  logic                out_stall;
  logic                out_present;
  logic [1:0]          out_status;
  logic [OCC_W-1:0]    out_occupancy;

  int fail_count;
  int outstanding;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int holds_served   = 0;

  logic [HANDLE_W-1:0] handle_pool [POOL_SIZE];

  compacting_unique_set_table DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_handle     (in_handle),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_present   (out_present),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  compacting_unique_set_table_check set_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_handle     (in_handle),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_present   (out_present),
    .out_status    (out_status),
    .out_occupancy (out_occupancy),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // one request transaction; returns at the falling edge after acceptance
  task automatic send_request(action_t act, logic [HANDLE_W-1:0] h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_handle <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly handles from a pool slightly larger than the table, so hits,
  // misses and a full table all happen
  function automatic logic [HANDLE_W-1:0] pick_handle();
    if ($urandom_range(99) < 75) begin
      return handle_pool[$urandom_range(POOL_SIZE - 1)];
    end
    return $urandom;
  endfunction

  function automatic action_t pick_action(int mode);
    int roll;
    int add_w;
    int rem_w;
    roll = $urandom_range(99);
    case (mode)
      MODE_FILL: begin
        add_w = 80;
        rem_w = 8;
      end
      MODE_CHURN: begin
        add_w = 40;
        rem_w = 35;
      end
      default: begin
        add_w = 15;
        rem_w = 60;
      end
    endcase
    if (roll < add_w) return ACT_ADD;
    if (roll < add_w + rem_w) return ACT_REMOVE;
    if (roll < 98) return ACT_QUERY;
    return ACT_CLEAR;
  endfunction

  task automatic run_random(int count, int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) begin
        hold_requests++;
      end
      send_request(pick_action((i / 100) % 3), pick_handle());
    end
  endtask

  // result side: random stall, or a long hold-off when one is requested
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served = holds_served + 1;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    in_valid  = 1'b0;
    in_action = ACT_ADD;
    in_handle = '0;
    rst_n     = 1'b0;
    handle_pool[0] = H_ZERO;
    handle_pool[1] = H_ONES;
    for (int i = 2; i < POOL_SIZE; i++) begin
      handle_pool[i] = $urandom;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, duplicates, first and last slot removal, clear with a member
    send_request(ACT_QUERY,  H_ZERO);
    send_request(ACT_REMOVE, H_ONES);
    send_request(ACT_CLEAR,  H_ZERO);
    send_request(ACT_ADD,    H_ZERO);
    send_request(ACT_ADD,    H_ONES);
    send_request(ACT_ADD,    H_ALT0);
    send_request(ACT_ADD,    H_ZERO);
    send_request(ACT_QUERY,  H_ONES);
    send_request(ACT_QUERY,  H_ALT1);
    send_request(ACT_REMOVE, H_ZERO);
    send_request(ACT_QUERY,  H_ALT0);
    send_request(ACT_REMOVE, H_ALT0);
    send_request(ACT_REMOVE, H_ALT0);
    send_request(ACT_ADD,    H_ALT1);
    send_request(ACT_ADD,    H_MSB);
    send_request(ACT_CLEAR,  H_ONES);
    send_request(ACT_QUERY,  H_ONES);
    send_request(ACT_ADD,    H_LSB);
    send_request(ACT_CLEAR,  H_ZERO);

    // first phase also carries the long hold-off so the table backs up
    run_random(PHASE_ITEMS, PHASE_ITEMS / 2);
    send_idle_pct  = 56;
    recv_stall_pct = 0;
    run_random(PHASE_ITEMS, -1);
    send_idle_pct  = 0;
    recv_stall_pct = 56;
    run_random(PHASE_ITEMS, -1);
    send_idle_pct  = 27;
    recv_stall_pct = 27;
    run_random(PHASE_ITEMS, -1);

    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("compacting_unique_set_table verification clean");
    end else begin
      $display("compacting_unique_set_table verification failed");
    end
    $finish;
  end

  initial begin
    #LIMIT_NS;
    $display("compacting_unique_set_table verification failed");
    $finish;
  end

endmodule
